[design/cmsg_pkg.sv]
`default_nettype none
package cmsg_pkg;

  typedef enum logic [2:0] {
    ACT_SEED      = 3'd0,
    ACT_SEED_PAIR = 3'd1,
    ACT_NEXT      = 3'd2,
    ACT_STEP      = 3'd3,
    ACT_SKIP      = 3'd4,
    ACT_SPLIT     = 3'd5
  } action_t;

  localparam logic KIND_RANDOM = 1'b0;
  localparam logic KIND_CHILD  = 1'b1;

  localparam logic [63:0] MULT_X  = 64'h6a5d39eae116586d;
  localparam logic [63:0] MULT_Y  = 64'h3b91f78bdac4c89d;
  localparam logic [63:0] SEED_Y  = 64'd36243600;
  localparam logic [63:0] RESET_X = 64'd123456789;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

endpackage
`default_nettype wire

[design/cmsg_mul.sv]
`default_nettype none
module cmsg_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmsg_pkg::mul_req_t req,
  output cmsg_pkg::mul_rsp_t      rsp
);
  import cmsg_pkg::*;

  // The low 64 bits of a 64 by 64 product, built from three 32 by 32 partial
  // products on one multiplier, one per cycle.
  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  ph_r;
  logic        busy_r, done_r;
  logic [31:0] opa, opb;
  logic [63:0] pp;

  always_comb begin
    case (ph_r)
      2'd0:    begin opa = a_r[31:0];  opb = b_r[31:0];  end
      2'd1:    begin opa = a_r[63:32]; opb = b_r[31:0];  end
      default: begin opa = a_r[31:0];  opb = b_r[63:32]; end
    endcase
    pp = opa * opb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        a_r    <= req.a;
        b_r    <= req.b;
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        if (ph_r == 2'd0) begin
          acc_r <= pp;
        end else begin
          acc_r[63:32] <= acc_r[63:32] + pp[31:0];
        end
        if (ph_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule
`default_nettype wire

[design/combined_mlcg_skip_generator.sv]
`default_nettype none
// Seed and seed pair load the state directly; step takes one product and next two.
// Skip tests one distance bit at a time and runs its products on the shared
// multiplier: a squaring for every bit and one more product per set bit; split
// adds a preparation step and one product. A product is issued, the multiplier
// forms three partial products and the result is taken. One word is worked at a time.
// Synchronous active-low reset loads x = 123456789, y = 36243600 and offset = 0.
module combined_mlcg_skip_generator #(
  parameter int SKIP_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [63:0] in_seed_x,
  input  wire logic [63:0] in_seed_y,
  input  wire logic [63:0] in_distance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [31:0]      out_random_value,
  output logic [63:0]      out_child_x,
  output logic [63:0]      out_child_y,
  output logic [63:0]      out_child_offset
);
  import cmsg_pkg::*;

  localparam int BW = $clog2(SKIP_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT_X, S_NEXT_Y, S_STEP, S_SP_PREP,
    S_SK_TEST, S_SK_MUL, S_SK_SQ, S_SP_CHILD, S_HOLD
  } state_t;

  state_t      state_r;
  logic [63:0] x_r, y_r, off_r, dist_r, pw_r;
  logic [BW-1:0] bit_r;
  logic        started_r, split_r, kind_r;
  logic        out_valid_r, out_kind_r;
  logic [31:0] out_rand_r;
  logic [63:0] out_cx_r, out_cy_r, out_co_r;

  mul_req_t req;
  mul_rsp_t rsp;
  logic     mul_step_done;

  cmsg_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  always_comb begin
    req.start = 1'b0;
    req.a     = x_r;
    req.b     = MULT_X;
    unique case (state_r)
      S_NEXT_X, S_STEP, S_SK_MUL, S_SP_CHILD: begin
        req.start = !started_r;
        req.a     = x_r;
        req.b     = (state_r == S_SK_MUL) ? pw_r : MULT_X;
      end
      S_NEXT_Y: begin
        req.start = !started_r;
        req.a     = y_r;
        req.b     = MULT_Y;
      end
      S_SK_SQ: begin
        req.start = !started_r;
        req.a     = pw_r;
        req.b     = pw_r;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
    mul_step_done = started_r && rsp.done;
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= RESET_X;
      y_r         <= SEED_Y;
      off_r       <= 64'd0;
      started_r   <= 1'b0;
      split_r     <= 1'b0;
      kind_r      <= KIND_RANDOM;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_HOLD) begin
        out_valid_r <= 1'b0;
      end
      if (req.start) begin
        started_r <= 1'b1;
      end
      if (mul_step_done) begin
        started_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_action)
              ACT_SEED: begin
                x_r   <= {32'd0, in_seed_x[31:0]};
                y_r   <= SEED_Y;
                off_r <= 64'd0;
              end
              ACT_SEED_PAIR: begin
                x_r   <= in_seed_x;
                y_r   <= in_seed_y;
                off_r <= 64'd0;
              end
              ACT_NEXT: state_r <= S_NEXT_X;
              ACT_STEP: state_r <= S_STEP;
              ACT_SKIP: begin
                dist_r  <= in_distance;
                off_r   <= off_r + in_distance;
                pw_r    <= MULT_X;
                bit_r   <= '0;
                split_r <= 1'b0;
                state_r <= S_SK_TEST;
              end
              ACT_SPLIT: begin
                dist_r  <= {off_r[61:0], 2'b00} + off_r + 64'd1;
                pw_r    <= MULT_X;
                bit_r   <= '0;
                split_r <= 1'b1;
                state_r <= S_SP_PREP;
              end
              default: begin
              end
            endcase
          end
        end
        S_NEXT_X: begin
          if (mul_step_done) begin
            x_r     <= rsp.p;
            state_r <= S_NEXT_Y;
          end
        end
        S_NEXT_Y: begin
          if (mul_step_done) begin
            y_r     <= rsp.p;
            kind_r  <= KIND_RANDOM;
            state_r <= S_HOLD;
          end
        end
        S_STEP: begin
          if (mul_step_done) begin
            x_r     <= rsp.p;
            off_r   <= off_r + 64'd1;
            state_r <= S_IDLE;
          end
        end
        S_SP_PREP: begin
          off_r   <= off_r + dist_r;
          state_r <= S_SK_TEST;
        end
        S_SK_TEST: begin
          if (bit_r == BW'(SKIP_BITS) || dist_r == 64'd0) begin
            state_r <= split_r ? S_SP_CHILD : S_IDLE;
          end else if (dist_r[0]) begin
            state_r <= S_SK_MUL;
          end else begin
            state_r <= S_SK_SQ;
          end
        end
        S_SK_MUL: begin
          if (mul_step_done) begin
            x_r     <= rsp.p;
            state_r <= S_SK_SQ;
          end
        end
        S_SK_SQ: begin
          if (mul_step_done) begin
            pw_r    <= rsp.p;
            dist_r  <= {1'b0, dist_r[63:1]};
            bit_r   <= bit_r + BW'(1);
            state_r <= S_SK_TEST;
          end
        end
        S_SP_CHILD: begin
          if (mul_step_done) begin
            kind_r  <= KIND_CHILD;
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            if (kind_r == KIND_CHILD) begin
              out_rand_r <= 32'd0;
              out_cx_r   <= rsp.p;
              out_cy_r   <= y_r;
              out_co_r   <= off_r + 64'd1;
            end else begin
              out_rand_r <= 32'((x_r + y_r) >> 32);
              out_cx_r   <= 64'd0;
              out_cy_r   <= 64'd0;
              out_co_r   <= 64'd0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_random_value = out_rand_r;
  assign out_child_x      = out_cx_r;
  assign out_child_y      = out_cy_r;
  assign out_child_offset = out_co_r;

endmodule
`default_nettype wire
